[rtl/rls_pkg.sv]
// shared types and constants for the replicated log store
package rls_pkg;

	localparam int DEF_LOG_DEPTH    = 1024;
	localparam int DEF_PAYLOAD_BITS = 32;
	localparam int QUEUE_DEPTH      = 2;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_HEADER = 2'd1,
		OP_ENTRY  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NONCONTIG   = 3'd1,
		ST_PREV_OOB    = 3'd2,
		ST_PREV_TERM   = 3'd3,
		ST_ZERO_INDEX  = 3'd4,
		ST_FULL        = 3'd5,
		ST_SKIPPED     = 3'd6,
		ST_READ_MISS   = 3'd7
	} status_t;

	// one classified beat waiting for the back end
	typedef struct packed {
		op_t         op;
		logic [15:0] idx;
		logic        idx_zero;
		logic [31:0] term;
		logic [31:0] payload;
		logic        last;
	} item_t;

endpackage

[rtl/rls_front.sv]
// front end: accepts request beats, classifies them and queues them
module rls_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [1:0]    cmd,
	input  logic [15:0]   index,
	input  logic [31:0]   term,
	input  logic [31:0]   payload,
	input  logic          last_in_batch,
	output logic          q_valid,
	output rls_pkg::item_t q_item,
	input  logic          q_pop
);

	localparam int PTR_W = $clog2(rls_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rls_pkg::QUEUE_DEPTH + 1);

	rls_pkg::item_t slot_q [rls_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	rls_pkg::item_t   new_item;
	logic             push;
	logic             pop;

	always_comb begin
		new_item.op       = rls_pkg::op_t'(cmd);
		new_item.idx      = index;
		new_item.idx_zero = (index == 16'd0);
		new_item.term     = term;
		new_item.payload  = payload;
		new_item.last     = last_in_batch;
	end

	assign req_stall = (fill_q == CNT_W'(rls_pkg::QUEUE_DEPTH));
	assign push      = req_valid && !req_stall;
	assign q_valid   = (fill_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(rls_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(rls_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/rls_back.sv]
// back end: log memories, append / replication / read execution, result register
module rls_back #(
	parameter int LOG_DEPTH    = rls_pkg::DEF_LOG_DEPTH,
	parameter int PAYLOAD_BITS = rls_pkg::DEF_PAYLOAD_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  rls_pkg::item_t q_item,
	output logic           q_pop,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output logic [2:0]     status,
	output logic           conflict_truncated,
	output logic           batch_ok,
	output logic           batch_done,
	output logic [31:0]    read_term,
	output logic [31:0]    read_payload,
	output logic [15:0]    log_last_index,
	output logic [31:0]    log_last_term
);

	localparam int ADDR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CNT_W  = $clog2(LOG_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	logic [31:0]             term_mem [LOG_DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_mem  [LOG_DEPTH];

	state_t                  state_q;
	rls_pkg::item_t          item_s1;
	logic [31:0]             rterm_s1;
	logic [PAYLOAD_BITS-1:0] rpay_s1;
	logic [CNT_W-1:0]        count_q;
	logic [31:0]             newest_q;
	logic                    open_q;
	logic                    failed_q;

	logic                    rsp_valid_q;
	rls_pkg::status_t        status_q;
	logic                    trunc_q;
	logic                    bok_q;
	logic                    bdone_q;
	logic [31:0]             rterm_q;
	logic [31:0]             rpay_q;

	logic [ADDR_W-1:0]       rd_addr;
	logic [ADDR_W-1:0]       wr_addr;
	logic                    fire;

	logic [16:0]             idx17;
	logic [16:0]             cnt17;
	logic                    in_range;
	logic                    contig;
	logic                    full;
	logic                    term_hit;

	rls_pkg::status_t        nx_status;
	logic                    nx_trunc;
	logic                    nx_bok;
	logic                    nx_bdone;
	logic [31:0]             nx_rterm;
	logic [31:0]             nx_rpay;
	logic [CNT_W-1:0]        nx_count;
	logic [31:0]             nx_newest;
	logic                    nx_open;
	logic                    nx_failed;
	logic                    wr_en;

	assign q_pop   = (state_q == S_IDLE) && q_valid;
	assign fire    = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign rd_addr = ADDR_W'(q_item.idx - 16'd1);
	assign wr_addr = ADDR_W'(item_s1.idx - 16'd1);

	assign idx17    = 17'(item_s1.idx);
	assign cnt17    = 17'(count_q);
	assign in_range = !item_s1.idx_zero && (idx17 <= cnt17);
	assign contig   = (idx17 == cnt17 + 17'd1);
	assign full     = (cnt17 >= 17'(LOG_DEPTH));
	assign term_hit = (rterm_s1 == item_s1.term);

	always_comb begin
		nx_status = rls_pkg::ST_OK;
		nx_trunc  = 1'b0;
		nx_bok    = 1'b0;
		nx_bdone  = 1'b0;
		nx_rterm  = '0;
		nx_rpay   = '0;
		nx_count  = count_q;
		nx_newest = newest_q;
		nx_open   = open_q;
		nx_failed = failed_q;
		wr_en     = 1'b0;
		unique case (item_s1.op)
			rls_pkg::OP_APPEND: begin
				if (!contig) begin
					nx_status = rls_pkg::ST_NONCONTIG;
				end else if (full) begin
					nx_status = rls_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					nx_count  = count_q + CNT_W'(1);
					nx_newest = item_s1.term;
				end
			end
			rls_pkg::OP_READ: begin
				if (!in_range) begin
					nx_status = rls_pkg::ST_READ_MISS;
				end else begin
					nx_rterm = rterm_s1;
					nx_rpay  = 32'(rpay_s1);
				end
			end
			rls_pkg::OP_HEADER: begin
				nx_open = 1'b1;
				if (idx17 > cnt17) begin
					nx_status = rls_pkg::ST_PREV_OOB;
				end else if (!item_s1.idx_zero && !term_hit) begin
					nx_status = rls_pkg::ST_PREV_TERM;
				end
				nx_failed = (nx_status != rls_pkg::ST_OK);
			end
			rls_pkg::OP_ENTRY: begin
				// an entry with no open batch starts one with a clean slate
				nx_open = 1'b1;
				if (open_q && failed_q) begin
					nx_status = rls_pkg::ST_SKIPPED;
				end else if (item_s1.idx_zero) begin
					nx_status = rls_pkg::ST_ZERO_INDEX;
				end else if (in_range) begin
					if (!term_hit) begin
						// cut the tail back to index-1, then the append always fits
						wr_en     = 1'b1;
						nx_trunc  = 1'b1;
						nx_count  = CNT_W'(item_s1.idx);
						nx_newest = item_s1.term;
					end
				end else if (!contig) begin
					nx_status = rls_pkg::ST_NONCONTIG;
				end else if (full) begin
					nx_status = rls_pkg::ST_FULL;
				end else begin
					wr_en     = 1'b1;
					nx_count  = count_q + CNT_W'(1);
					nx_newest = item_s1.term;
				end
				nx_failed = (nx_status != rls_pkg::ST_OK);
			end
			default: begin
				nx_status = rls_pkg::ST_OK;
			end
		endcase
		if (item_s1.op == rls_pkg::OP_HEADER || item_s1.op == rls_pkg::OP_ENTRY) begin
			nx_bok = !nx_failed;
			if (item_s1.last) begin
				nx_bdone  = 1'b1;
				nx_open   = 1'b0;
				nx_failed = 1'b0;
			end
		end
	end

	// stored term/payload read on the pop, written on the execute beat
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1  <= q_item;
			rterm_s1 <= term_mem[rd_addr];
			rpay_s1  <= pay_mem[rd_addr];
		end
		if (fire && wr_en) begin
			term_mem[wr_addr] <= item_s1.term;
			pay_mem[wr_addr]  <= PAYLOAD_BITS'(item_s1.payload);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= nx_status;
			trunc_q  <= nx_trunc;
			bok_q    <= nx_bok;
			bdone_q  <= nx_bdone;
			rterm_q  <= nx_rterm;
			rpay_q   <= nx_rpay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			newest_q    <= '0;
			open_q      <= 1'b0;
			failed_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				count_q  <= nx_count;
				newest_q <= nx_newest;
				open_q   <= nx_open;
				failed_q <= nx_failed;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign status             = status_q;
	assign conflict_truncated = trunc_q;
	assign batch_ok           = bok_q;
	assign batch_done         = bdone_q;
	assign read_term          = rterm_q;
	assign read_payload       = rpay_q;
	// log state is only touched on an execute beat, so it matches the held result
	assign log_last_index     = 16'(count_q);
	assign log_last_term      = newest_q;

endmodule

[rtl/replicated_log_store.sv]
// a request beat passes the queue, the pop register and the result register
// the back end pops a new beat only once the previous one has executed, so the
// stored-term read follows the previous beat's log write before execute checks it
// a 2-entry queue lets the request side keep going while the result side stalls
// reset clears entry count, newest term and batch state; the log memories are not
// cleared and need no clearing pass, beats are taken right after reset
module replicated_log_store #(
	parameter int LOG_DEPTH    = rls_pkg::DEF_LOG_DEPTH,
	parameter int PAYLOAD_BITS = rls_pkg::DEF_PAYLOAD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] index,
	input  logic [31:0] term,
	input  logic [31:0] payload,
	input  logic        last_in_batch,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic        conflict_truncated,
	output logic        batch_ok,
	output logic        batch_done,
	output logic [31:0] read_term,
	output logic [31:0] read_payload,
	output logic [15:0] log_last_index,
	output logic [31:0] log_last_term
);

	logic           q_valid;
	logic           q_pop;
	rls_pkg::item_t q_item;

	rls_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.cmd           (cmd),
		.index         (index),
		.term          (term),
		.payload       (payload),
		.last_in_batch (last_in_batch),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	rls_back #(
		.LOG_DEPTH    (LOG_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_valid            (q_valid),
		.q_item             (q_item),
		.q_pop              (q_pop),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.status             (status),
		.conflict_truncated (conflict_truncated),
		.batch_ok           (batch_ok),
		.batch_done         (batch_done),
		.read_term          (read_term),
		.read_payload       (read_payload),
		.log_last_index     (log_last_index),
		.log_last_term      (log_last_term)
	);

endmodule

[rtl/rls_checker.sv]
// port-level checks for the replicated log store, bound to the top level
module rls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [2:0]  status,
	input logic        conflict_truncated,
	input logic        batch_ok,
	input logic        batch_done,
	input logic [31:0] read_term,
	input logic [31:0] read_payload,
	input logic [15:0] log_last_index,
	input logic [31:0] log_last_term
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(read_term)
			&& $stable(log_last_index) && $stable(log_last_term))
		else $error("result beat changed while stalled");

	// a read miss returns no entry data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == rls_pkg::ST_READ_MISS |-> read_term == 32'd0
			&& read_payload == 32'd0 && !batch_ok && !batch_done)
		else $error("read miss carries entry data");

	// a truncation always ends in a successful append of that entry
	a_trunc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && conflict_truncated |-> status == rls_pkg::ST_OK && batch_ok
			&& log_last_index != 16'd0)
		else $error("truncation without a good append");

	// a failing status inside a batch clears the running batch flag
	a_fail_bok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == rls_pkg::ST_SKIPPED || status == rls_pkg::ST_PREV_OOB
			|| status == rls_pkg::ST_PREV_TERM || status == rls_pkg::ST_ZERO_INDEX)
			|-> !batch_ok)
		else $error("batch reported ok after a failure");

endmodule

bind replicated_log_store rls_checker u_rls_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp_valid),
	.rsp_stall          (rsp_stall),
	.status             (status),
	.conflict_truncated (conflict_truncated),
	.batch_ok           (batch_ok),
	.batch_done         (batch_done),
	.read_term          (read_term),
	.read_payload       (read_payload),
	.log_last_index     (log_last_index),
	.log_last_term      (log_last_term)
);
